// ===== rtl/lbt_pkg.sv =====
// Shared types and constants for the learning bridge table with aging.
package lbt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 8;
  localparam int TIME_W        = 32;
  localparam int COUNT_W       = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_LEARN  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] current_time;
    logic [TIME_W-1:0] cutoff_time;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [PORT_W-1:0]  found_port;
    status_t            status;
    logic [COUNT_W-1:0] removed_count;
  } rsp_t;

  // Request travelling down the row of cells, collecting partial results.
  typedef struct packed {
    logic               active;
    req_t               req;
    logic               found;
    logic [PORT_W-1:0]  found_port;
    logic               claimed;
    logic [COUNT_W-1:0] removed_count;
  } tok_t;

  // End-of-pass broadcast that resolves a tentative insert.
  typedef struct packed {
    logic settle;
    logic commit;
  } settle_t;

endpackage

// ===== rtl/learning_bridge_table_with_aging_core.sv =====
// A request is taken only while the row is idle and no finished result is waiting.
// It steps through the row of TABLE_ENTRIES slot cells, each registering it in
// turn; the pass is settled and the result captured as it leaves the last cell,
// and the result is then handed to the output register.
// A finished response waits in the output register while the next request runs.
// Reset: synchronous, clears every slot's valid bit and all handshake state;
// the table is usable in the first cycle after reset.
module learning_bridge_table_with_aging_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lbt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lbt_pkg::rsp_t rsp
);

  lbt_pkg::tok_t    tok [lbt_pkg::TABLE_ENTRIES+1];
  lbt_pkg::settle_t settle;

  lbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .tok_head  (tok[0]),
    .tok_tail  (tok[lbt_pkg::TABLE_ENTRIES]),
    .settle    (settle)
  );

  for (genvar k = 0; k < lbt_pkg::TABLE_ENTRIES; k++) begin : g_cell
    lbt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .settle  (settle),
      .tok_out (tok[k+1])
    );
  end

endmodule

// ===== rtl/lbt_cell.sv =====
// One table slot: holds an entry and processes the request passing through it.
module lbt_cell (
  input  logic            clk,
  input  logic            rst,
  input  lbt_pkg::tok_t   tok_in,
  input  lbt_pkg::settle_t settle,
  output lbt_pkg::tok_t   tok_out
);

  logic                        valid;
  logic                        pending;
  logic [lbt_pkg::ADDR_W-1:0]  address;
  logic [lbt_pkg::PORT_W-1:0]  port;
  logic [lbt_pkg::TIME_W-1:0]  stamp;

  logic          match;
  logic          claim;
  logic          refresh;
  logic          drop;
  lbt_pkg::tok_t tok_next;

  assign match = tok_in.active && valid && (address == tok_in.req.address);

  always_comb begin
    tok_next = tok_in;
    claim    = 1'b0;
    refresh  = 1'b0;
    drop     = 1'b0;
    if (tok_in.active) begin
      unique case (tok_in.req.operation)
        lbt_pkg::OP_LOOKUP: begin
          if (match) begin
            tok_next.found      = 1'b1;
            tok_next.found_port = port;
          end
        end
        lbt_pkg::OP_LEARN: begin
          if (match) begin
            tok_next.found = 1'b1;
            refresh        = 1'b1;
          end else if (!valid && !tok_in.claimed) begin
            // take the lowest free slot tentatively; settled at end of pass
            tok_next.claimed = 1'b1;
            claim            = 1'b1;
          end
        end
        lbt_pkg::OP_REMOVE: begin
          if (match) begin
            tok_next.found = 1'b1;
            drop           = 1'b1;
          end
        end
        lbt_pkg::OP_PURGE: begin
          if (valid && (stamp <= tok_in.req.cutoff_time)) begin
            drop = 1'b1;
            if (tok_in.removed_count != lbt_pkg::COUNT_MAX) begin
              tok_next.removed_count = tok_in.removed_count + lbt_pkg::COUNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      pending        <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
      if (drop) begin
        valid <= 1'b0;
      end else if (settle.settle && pending) begin
        valid <= settle.commit;
      end
      if (claim) begin
        pending <= 1'b1;
      end else if (settle.settle) begin
        pending <= 1'b0;
      end
    end
    tok_out.req           <= tok_next.req;
    tok_out.found         <= tok_next.found;
    tok_out.found_port    <= tok_next.found_port;
    tok_out.claimed       <= tok_next.claimed;
    tok_out.removed_count <= tok_next.removed_count;
  end

  always_ff @(posedge clk) begin
    if (claim || refresh) begin
      port  <= tok_in.req.port;
      stamp <= tok_in.req.current_time;
    end
    if (claim) begin
      address <= tok_in.req.address;
    end
  end

endmodule

// ===== rtl/lbt_ctrl.sv =====
// Request injection, end-of-pass settle and result buffering for the cell row.
module lbt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lbt_pkg::req_t    req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lbt_pkg::rsp_t    rsp,
  output lbt_pkg::tok_t    tok_head,
  input  lbt_pkg::tok_t    tok_tail,
  output lbt_pkg::settle_t settle
);

  logic          busy;
  logic          done_valid;
  lbt_pkg::rsp_t done;
  lbt_pkg::rsp_t result;
  logic          accept;
  logic          drain;

  assign req_ready = !busy && !done_valid;
  assign accept    = req_valid && req_ready;
  assign drain     = done_valid && (!rsp_valid || rsp_ready);

  always_comb begin
    tok_head               = '0;
    tok_head.active        = accept;
    tok_head.req           = req;
  end

  always_comb begin
    settle.settle = tok_tail.active;
    settle.commit = tok_tail.active && (tok_tail.req.operation == lbt_pkg::OP_LEARN) &&
                    !tok_tail.found && tok_tail.claimed;
  end

  always_comb begin
    result               = '0;
    result.found         = tok_tail.found;
    result.removed_count = tok_tail.removed_count;
    result.status        = lbt_pkg::ST_DONE;
    unique case (tok_tail.req.operation)
      lbt_pkg::OP_LOOKUP: begin
        result.found_port = tok_tail.found_port;
        if (!tok_tail.found) result.status = lbt_pkg::ST_MISS;
      end
      lbt_pkg::OP_LEARN: begin
        if (!tok_tail.found && !tok_tail.claimed) result.status = lbt_pkg::ST_FULL;
      end
      lbt_pkg::OP_REMOVE: begin
        if (!tok_tail.found) result.status = lbt_pkg::ST_MISS;
      end
      lbt_pkg::OP_PURGE: begin
        result.found = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tok_tail.active) begin
        busy <= 1'b0;
      end
      if (tok_tail.active) begin
        done_valid <= 1'b1;
      end else if (drain) begin
        done_valid <= 1'b0;
      end
      if (drain) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_tail.active) done <= result;
    if (drain) rsp <= done;
  end

endmodule

// ===== rtl/lbt_checker.sv =====
// Port-level checks for the bridge table core, bound to the top level.
module lbt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input lbt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input lbt_pkg::rsp_t rsp
);

  // hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_busy_pass: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##(lbt_pkg::TABLE_ENTRIES + 1) !req_ready)
    else $error("request taken before the previous pass finished");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == lbt_pkg::ST_DONE)
    else $error("match reported with a failing status");

  a_port_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.found_port != '0) |-> rsp.found && (rsp.removed_count == '0))
    else $error("port returned without a match");

  a_purge_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.removed_count != '0) |->
      !rsp.found && (rsp.status == lbt_pkg::ST_DONE))
    else $error("removal count on a non-purge response");

endmodule

bind learning_bridge_table_with_aging_core lbt_checker u_lbt_checker (.*);

// ===== tb/learning_bridge_table_with_aging_core_test.sv =====
// Self-checking testbench for the learning bridge table with aging, with its own table predictor.
module learning_bridge_table_with_aging_core_test;

  localparam int POOL_SIZE  = 96;
  localparam int BURST_LEN  = 72;
  localparam int MIXED_LEN  = 210;

  // Tracks the forwarding table and the responses it implies, oldest first.
  class table_scoreboard;
    bit                         slot_used  [lbt_pkg::TABLE_ENTRIES];
    logic [lbt_pkg::ADDR_W-1:0] slot_addr  [lbt_pkg::TABLE_ENTRIES];
    logic [lbt_pkg::PORT_W-1:0] slot_port  [lbt_pkg::TABLE_ENTRIES];
    logic [lbt_pkg::TIME_W-1:0] slot_stamp [lbt_pkg::TABLE_ENTRIES];
    lbt_pkg::rsp_t              pending_rsp[$];
    int                         mismatches;
    int                         requests;
    int                         lookup_hits;
    int                         full_drops;
    int                         aged_out;

    function int find_slot(logic [lbt_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < lbt_pkg::TABLE_ENTRIES; i++)
        if (slot_used[i] && slot_addr[i] == addr) return i;
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < lbt_pkg::TABLE_ENTRIES; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    function void note_request(lbt_pkg::req_t r);
      lbt_pkg::rsp_t e;
      int            hit;
      int            slot;
      e = '0;
      e.status = lbt_pkg::ST_DONE;
      hit = find_slot(r.address);
      requests++;
      case (r.operation)
        lbt_pkg::OP_LOOKUP: begin
          if (hit >= 0) begin
            e.found = 1'b1;
            e.found_port = slot_port[hit];
            lookup_hits++;
          end else begin
            e.status = lbt_pkg::ST_MISS;
          end
        end
        lbt_pkg::OP_LEARN: begin
          if (hit >= 0) begin
            e.found = 1'b1;
            slot_port[hit] = r.port;
            slot_stamp[hit] = r.current_time;
          end else begin
            slot = free_slot();
            if (slot >= 0) begin
              slot_used[slot] = 1'b1;
              slot_addr[slot] = r.address;
              slot_port[slot] = r.port;
              slot_stamp[slot] = r.current_time;
            end else begin
              e.status = lbt_pkg::ST_FULL;
              full_drops++;
            end
          end
        end
        lbt_pkg::OP_REMOVE: begin
          if (hit >= 0) begin
            e.found = 1'b1;
            slot_used[hit] = 1'b0;
          end else begin
            e.status = lbt_pkg::ST_MISS;
          end
        end
        default: begin
          for (int i = 0; i < lbt_pkg::TABLE_ENTRIES; i++) begin
            if (slot_used[i] && slot_stamp[i] <= r.cutoff_time) begin
              slot_used[i] = 1'b0;
              aged_out++;
              if (e.removed_count != lbt_pkg::COUNT_MAX) e.removed_count++;
            end
          end
        end
      endcase
      pending_rsp.push_back(e);
    endfunction

    function void check_response(lbt_pkg::rsp_t got);
      lbt_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, got.found);
        mismatches++;
      end
      if (got.found_port !== e.found_port) begin
        $error("found_port: expected %0d, got %0d", e.found_port, got.found_port);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        mismatches++;
      end
      if (got.removed_count !== e.removed_count) begin
        $error("removed_count: expected %0d, got %0d", e.removed_count,
               got.removed_count);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  lbt_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  lbt_pkg::rsp_t rsp;

  table_scoreboard            sb;
  int                         send_idle_pct = 0;
  int                         rsp_stall_pct = 0;
  logic [lbt_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];
  logic [lbt_pkg::TIME_W-1:0] tick;

  learning_bridge_table_with_aging_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("[learning_bridge_table_with_aging_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  function automatic lbt_pkg::req_t make_req(lbt_pkg::op_t op,
                                             logic [lbt_pkg::ADDR_W-1:0] addr,
                                             logic [lbt_pkg::PORT_W-1:0] port,
                                             logic [lbt_pkg::TIME_W-1:0] now,
                                             logic [lbt_pkg::TIME_W-1:0] cutoff);
    lbt_pkg::req_t r;
    r.operation = op;
    r.address = addr;
    r.port = port;
    r.current_time = now;
    r.cutoff_time = cutoff;
    return r;
  endfunction

  // Hold the beat until accepted; drop valid only across an idle gap.
  task automatic send_request(input lbt_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [lbt_pkg::TIME_W-1:0] pick_time();
    tick += $urandom_range(0, 1000);
    return ($urandom_range(0, 9) == 0) ? $urandom : tick;
  endfunction

  function automatic logic [lbt_pkg::TIME_W-1:0] pick_cutoff();
    int w;
    w = $urandom_range(0, 99);
    if (w < 25) return '1;
    if (w < 40) return '0;
    if (w < 80) return tick - $urandom_range(0, 20000);
    return $urandom;
  endfunction

  task automatic learn_burst();
    int start;
    start = $urandom_range(0, POOL_SIZE - 1);
    for (int k = 0; k < BURST_LEN; k++)
      send_request(make_req(lbt_pkg::OP_LEARN, addr_pool[(start + k) % POOL_SIZE],
                            8'($urandom_range(0, 255)), pick_time(), $urandom));
  endtask

  task automatic mixed_traffic();
    int                         w;
    lbt_pkg::op_t               op;
    logic [lbt_pkg::ADDR_W-1:0] addr;
    for (int k = 0; k < MIXED_LEN; k++) begin
      w = $urandom_range(0, 99);
      if (w < 35) op = lbt_pkg::OP_LOOKUP;
      else if (w < 70) op = lbt_pkg::OP_LEARN;
      else if (w < 90) op = lbt_pkg::OP_REMOVE;
      else op = lbt_pkg::OP_PURGE;
      addr = ($urandom_range(0, 9) == 0) ? $urandom
                                         : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(make_req(op, addr, 8'($urandom_range(0, 255)), pick_time(),
                            (op == lbt_pkg::OP_PURGE) ? pick_cutoff() : $urandom));
    end
  endtask

  task automatic directed_items();
    send_request(make_req(lbt_pkg::OP_LOOKUP, 32'h0, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_REMOVE, 32'h0, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_PURGE,  32'h0, 8'h00, 32'h0, 32'hFFFF_FFFF));
    send_request(make_req(lbt_pkg::OP_LEARN,  32'h0, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_LEARN,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
    send_request(make_req(lbt_pkg::OP_LOOKUP, 32'h0, 8'hFF, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h0));
    // refresh an existing entry with a new port and stamp
    send_request(make_req(lbt_pkg::OP_LEARN,  32'h0, 8'h5A, 32'd100, 32'h0));
    send_request(make_req(lbt_pkg::OP_LOOKUP, 32'h0, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_LEARN,  32'hA5A5_A5A5, 8'h01, 32'd50, 32'h0));
    send_request(make_req(lbt_pkg::OP_LEARN,  32'h5A5A_5A5A, 8'h02, 32'd200, 32'h0));
    // cutoff equal to a stamp removes that entry
    send_request(make_req(lbt_pkg::OP_PURGE,  32'h0, 8'h00, 32'h0, 32'd100));
    send_request(make_req(lbt_pkg::OP_PURGE,  32'h0, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 8'h00, 32'h0, 32'h0));
    send_request(make_req(lbt_pkg::OP_LEARN,  32'h1234_5678, 8'h80, 32'hFFFF_FFFF,
                          32'h0));
    send_request(make_req(lbt_pkg::OP_PURGE,  32'h0, 8'h00, 32'h0, 32'hFFFF_FFFE));
    send_request(make_req(lbt_pkg::OP_PURGE,  32'h0, 8'h00, 32'h0, 32'hFFFF_FFFF));
  endtask

  initial begin
    sb = new();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    tick = $urandom_range(0, 1000);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
        default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
      endcase
      learn_burst();
      mixed_traffic();
    end
    req_valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (lbt_pkg::TABLE_ENTRIES + 8) @(posedge clk);

    $display("Covered %0d requests over four handshake patterns: %0d lookup hits,",
             sb.requests, sb.lookup_hits);
    $display("%0d learns dropped on a full table, %0d entries aged out by purge.",
             sb.full_drops, sb.aged_out);
    if (sb.mismatches == 0) begin
      $display("[learning_bridge_table_with_aging_core] OK");
    end else begin
      $display("[learning_bridge_table_with_aging_core] ERROR");
    end
    $finish;
  end

endmodule
